@@ rtl/kmcm_pkg.sv @@
// Shared types and constants of the keyed multi-channel mailbox.
package kmcm_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF  = 16;

	localparam int WORD_W    = 64;
	localparam int MSG_WORDS = 4;
	localparam int MSG_W     = WORD_W * MSG_WORDS;
	localparam int ID_W      = 64;
	localparam int KEY_W     = 64;

	localparam int DL_W = 5;
	localparam logic [DL_W-1:0] DL_RESET = 5'd16;

	localparam int S_DATA_W = ID_W + KEY_W + MSG_W;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = MSG_W;
	localparam int M_USER_W = 3;

	typedef enum logic [S_USER_W-1:0] {
		ACT_CREATE  = 2'd0,
		ACT_CONNECT = 2'd1,
		ACT_SEND    = 2'd2,
		ACT_RECEIVE = 2'd3
	} action_t;

	typedef enum logic [M_USER_W-1:0] {
		STS_OK     = 3'd0,
		STS_NAME   = 3'd1,
		STS_ACCESS = 3'd2,
		STS_LEVEL  = 3'd3,
		STS_TABLE  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_EXEC,
		S_RESP
	} state_t;

endpackage

@@ rtl/kmcm_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
module kmcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/keyed_multi_channel_mailbox_top.sv @@
// Keyed multi-channel mailbox: channel table, message queues and request sequencing.
//
// Requests arrive on the s_ stream: s_tuser carries the action, s_tdata the channel
// id, the access key and four payload words. Each request produces exactly one
// response on the m_ stream: m_tuser carries the status, m_tdata the four words
// popped by a successful receive, and zeros for every other response.
// The depth limit register is written through cfg_wr_en and cfg_wr_data. The user
// must write it only while the block is idle; the block itself does not enforce
// this. It resets to 16, and the limit in use is capped at the queue depth.
// A request passes through capture, id match and table read, decision with table
// and message writes or message read, then response load, as the message read
// depends on the table read. The response is loaded into the output register that
// drives the m_ side, and s_tready is high again in the cycle after the load.
// A response waiting in the output register does not hold up the next request;
// only when the next response is ready and the receiver still stalls does the
// block wait in its last step, and s_tready stays low meanwhile.
// Reset clears all channel valid bits and the output valid flag, and returns the
// depth limit to 16.
// The channel table and message memories are not cleared: the content of an entry
// is only used after create or send has written it.
module keyed_multi_channel_mailbox_top #(
	parameter int NUM_CHANNELS = kmcm_pkg::NUM_CHANNELS_DEF,
	parameter int QUEUE_DEPTH  = kmcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// channel_id [63:0], access_key [127:64], send_word0..3 [383:128]
	input  logic [kmcm_pkg::S_DATA_W-1:0] s_tdata,
	// action [1:0]
	input  logic [kmcm_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// recv_word0..3 [255:0], 64 bits each from the lowest bit up
	output logic [kmcm_pkg::M_DATA_W-1:0] m_tdata,
	// status [2:0]
	output logic [kmcm_pkg::M_USER_W-1:0] m_tuser,
	input  logic                          cfg_wr_en,
	input  logic [kmcm_pkg::DL_W-1:0]     cfg_wr_data
);

	import kmcm_pkg::*;

	localparam int SW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int HW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W     = (CW > DL_W) ? CW : DL_W;
	localparam int MSG_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
	localparam int MA_W      = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CHAN_W    = KEY_W + 1 + HW + CW;

	state_t state_q, state_d;

	logic [DL_W-1:0]   depth_limit_q;
	action_t           req_action_q;
	logic [ID_W-1:0]   req_id_q;
	logic [KEY_W-1:0]  req_key_q;
	logic [MSG_W-1:0]  req_words_q;

	logic [NUM_CHANNELS-1:0] valid_q;
	logic [ID_W-1:0]         id_tag_q [NUM_CHANNELS];

	logic          hit_any, free_any;
	logic [SW-1:0] hit_slot, free_slot;
	logic          hit_s2, free_any_s2;
	logic [SW-1:0] slot_s2, free_slot_s2;

	logic              chan_rd_en;
	logic [CHAN_W-1:0] chan_rd_data;
	logic              chan_we, chan_we_d;
	logic [SW-1:0]     chan_wr_addr;
	logic [CHAN_W-1:0] chan_wr_data;

	logic [KEY_W-1:0] cur_key;
	logic             cur_conn;
	logic [HW-1:0]    cur_head, head_next, tail_pos;
	logic [CW-1:0]    cur_count;
	logic [CW:0]      tail_sum;
	logic [HW:0]      head_inc;
	logic [CMP_W-1:0] lim_eff, dl_ext, qd_c;
	logic             queue_full;

	logic             msg_we, msg_we_d, msg_rd_en, msg_rd_en_d;
	logic [MA_W-1:0]  msg_wr_addr, msg_rd_addr;
	logic [MSG_W-1:0] msg_rd_data;

	logic    cam_we, cam_we_d;
	logic    exec_en, out_load, out_free;
	status_t exec_status, status_s3;
	logic    recv_ok, recv_ok_s3;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [M_USER_W-1:0] m_tuser_q;

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: state_d = S_EXEC;
			S_EXEC:   state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		chan_rd_en = 1'b0;
		exec_en    = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			S_IDLE:   s_tready   = 1'b1;
			S_LOOKUP: chan_rd_en = 1'b1;
			S_EXEC:   exec_en    = 1'b1;
			S_RESP:   out_load   = out_free;
			default: ;
		endcase
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign chan_we   = exec_en && chan_we_d;
	assign msg_we    = exec_en && msg_we_d;
	assign msg_rd_en = exec_en && msg_rd_en_d;
	assign cam_we    = exec_en && cam_we_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			depth_limit_q <= DL_RESET;
			valid_q       <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				depth_limit_q <= cfg_wr_data;
			end
			if (cam_we) begin
				valid_q[free_slot_s2] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request capture, id tags and pipeline registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_action_q <= action_t'(s_tuser);
			req_id_q     <= s_tdata[ID_W-1:0];
			req_key_q    <= s_tdata[ID_W +: KEY_W];
			req_words_q  <= s_tdata[ID_W+KEY_W +: MSG_W];
		end
		if (cam_we) begin
			id_tag_q[free_slot_s2] <= req_id_q;
		end
		hit_s2       <= hit_any;
		slot_s2      <= hit_slot;
		free_any_s2  <= free_any;
		free_slot_s2 <= free_slot;
		if (exec_en) begin
			status_s3  <= exec_status;
			recv_ok_s3 <= recv_ok;
		end
		if (out_load) begin
			m_tuser_q <= status_s3;
			m_tdata_q <= recv_ok_s3 ? msg_rd_data : '0;
		end
	end

	// Associative id match and lowest free slot.
	always_comb begin
		hit_any   = 1'b0;
		hit_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (valid_q[i] && id_tag_q[i] == req_id_q) begin
				hit_any  = 1'b1;
				hit_slot = hit_slot | SW'(i);
			end
		end
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any  = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	kmcm_ram #(
		.WIDTH (CHAN_W),
		.DEPTH (NUM_CHANNELS),
		.AW    (SW)
	) u_chan_ram (
		.clk     (clk),
		.wr_en   (chan_we),
		.wr_addr (chan_wr_addr),
		.wr_data (chan_wr_data),
		.rd_en   (chan_rd_en),
		.rd_addr (hit_slot),
		.rd_data (chan_rd_data)
	);

	assign cur_key   = chan_rd_data[CHAN_W-1 -: KEY_W];
	assign cur_conn  = chan_rd_data[HW+CW];
	assign cur_head  = chan_rd_data[CW +: HW];
	assign cur_count = chan_rd_data[CW-1:0];

	assign dl_ext     = CMP_W'(depth_limit_q);
	assign qd_c       = CMP_W'(QUEUE_DEPTH);
	assign lim_eff    = (dl_ext > qd_c) ? qd_c : dl_ext;
	assign queue_full = CMP_W'(cur_count) >= lim_eff;

	assign tail_sum = (CW+1)'(cur_head) + (CW+1)'(cur_count);
	assign tail_pos = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		HW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
	assign head_inc  = {1'b0, cur_head} + (HW+1)'(1);
	assign head_next = (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);

	assign msg_wr_addr = MA_W'(slot_s2) * MA_W'(QUEUE_DEPTH) + MA_W'(tail_pos);
	assign msg_rd_addr = MA_W'(slot_s2) * MA_W'(QUEUE_DEPTH) + MA_W'(cur_head);

	// Request decision, table update and message write or read.
	always_comb begin
		exec_status  = STS_OK;
		chan_we_d    = 1'b0;
		chan_wr_addr = slot_s2;
		chan_wr_data = chan_rd_data;
		msg_we_d     = 1'b0;
		msg_rd_en_d  = 1'b0;
		cam_we_d     = 1'b0;
		recv_ok      = 1'b0;
		case (req_action_q)
			ACT_CREATE: begin
				if (hit_s2) begin
					exec_status = STS_NAME;
				end else if (!free_any_s2) begin
					exec_status = STS_TABLE;
				end else begin
					cam_we_d     = 1'b1;
					chan_we_d    = 1'b1;
					chan_wr_addr = free_slot_s2;
					chan_wr_data = {req_key_q, 1'b0, HW'(0), CW'(0)};
				end
			end
			ACT_CONNECT: begin
				if (!hit_s2 || cur_key != req_key_q || cur_conn) begin
					exec_status = STS_NAME;
				end else begin
					chan_we_d    = 1'b1;
					chan_wr_data = {cur_key, 1'b1, cur_head, cur_count};
				end
			end
			default: begin
				if (!hit_s2) begin
					exec_status = STS_NAME;
				end else if (cur_key != req_key_q || !cur_conn) begin
					exec_status = STS_ACCESS;
				end else if (req_action_q == ACT_SEND) begin
					if (queue_full) begin
						exec_status = STS_LEVEL;
					end else begin
						msg_we_d     = 1'b1;
						chan_we_d    = 1'b1;
						chan_wr_data = {cur_key, cur_conn, cur_head, cur_count + CW'(1)};
					end
				end else begin
					if (cur_count == '0) begin
						exec_status = STS_LEVEL;
					end else begin
						msg_rd_en_d  = 1'b1;
						recv_ok      = 1'b1;
						chan_we_d    = 1'b1;
						chan_wr_data = {cur_key, cur_conn, head_next, cur_count - CW'(1)};
					end
				end
			end
		endcase
	end

	kmcm_ram #(
		.WIDTH (MSG_W),
		.DEPTH (MSG_DEPTH),
		.AW    (MA_W)
	) u_msg_ram (
		.clk     (clk),
		.wr_en   (msg_we),
		.wr_addr (msg_wr_addr),
		.wr_data (req_words_q),
		.rd_en   (msg_rd_en),
		.rd_addr (msg_rd_addr),
		.rd_data (msg_rd_data)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/kmcm_checker.sv @@
// Port-level assertions for the keyed multi-channel mailbox and their binding.
module kmcm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [kmcm_pkg::M_DATA_W-1:0] m_tdata,
	input logic [kmcm_pkg::M_USER_W-1:0] m_tuser
);

	import kmcm_pkg::*;

	// A stalled response holds its content.
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("response changed while stalled");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= M_USER_W'(STS_TABLE))
		else $error("undefined status code");

	// Only a successful request can carry payload words.
	a_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != M_USER_W'(STS_OK) |-> m_tdata == '0)
		else $error("failed request returned payload words");

	// One request is in flight at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("request accepted while another is in progress");

endmodule

bind keyed_multi_channel_mailbox_top kmcm_checker u_kmcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the keyed multi-channel mailbox: it predicts and checks every response.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kmcm_pkg::*;

	localparam int CHANNELS = NUM_CHANNELS_DEF;
	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int POOL = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	class mailbox_scoreboard;
		typedef struct {
			status_t status;
			logic [M_DATA_W-1:0] words;
		} response_t;

		bit valid [CHANNELS];
		bit connected [CHANNELS];
		logic [ID_W-1:0] id_tag [CHANNELS];
		logic [KEY_W-1:0] key_tag [CHANNELS];
		bit [3:0] head [CHANNELS];
		bit [4:0] count [CHANNELS];
		logic [MSG_W-1:0] store [CHANNELS][DEPTH];
		bit [DL_W-1:0] limit;
		response_t awaited [$];
		int errors;
		int checked;
		int status_count [5];

		function new();
			limit = DL_RESET;
			for (int c = 0; c < CHANNELS; c++) begin
				valid[c] = 1'b0;
				connected[c] = 1'b0;
				head[c] = '0;
				count[c] = '0;
			end
		endfunction

		function int lookup(logic [ID_W-1:0] id);
			for (int c = 0; c < CHANNELS; c++) begin
				if (valid[c] && id_tag[c] == id)
					return c;
			end
			return -1;
		endfunction

		function void note_request(action_t act, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
				logic [MSG_W-1:0] msg);
			response_t r;
			int ch;
			int free_ch;
			int ceiling;
			int pos;
			r.status = STS_OK;
			r.words = '0;
			ch = lookup(id);
			ceiling = (limit > DEPTH) ? DEPTH : limit;
			if (act == ACT_CREATE) begin
				if (ch >= 0) begin
					r.status = STS_NAME;
				end else begin
					free_ch = -1;
					for (int c = CHANNELS - 1; c >= 0; c--) begin
						if (!valid[c])
							free_ch = c;
					end
					if (free_ch < 0) begin
						r.status = STS_TABLE;
					end else begin
						valid[free_ch] = 1'b1;
						id_tag[free_ch] = id;
						key_tag[free_ch] = key;
						connected[free_ch] = 1'b0;
						head[free_ch] = '0;
						count[free_ch] = '0;
					end
				end
			end else if (act == ACT_CONNECT) begin
				if (ch < 0 || key_tag[ch] != key || connected[ch])
					r.status = STS_NAME;
				else
					connected[ch] = 1'b1;
			end else if (ch < 0) begin
				r.status = STS_NAME;
			end else if (key_tag[ch] != key || !connected[ch]) begin
				r.status = STS_ACCESS;
			end else if (act == ACT_SEND) begin
				if (count[ch] >= ceiling) begin
					r.status = STS_LEVEL;
				end else begin
					pos = (head[ch] + count[ch]) % DEPTH;
					store[ch][pos] = msg;
					count[ch] = count[ch] + 1;
				end
			end else begin
				if (count[ch] == 0) begin
					r.status = STS_LEVEL;
				end else begin
					r.words = store[ch][head[ch]];
					head[ch] = head[ch] + 1;
					count[ch] = count[ch] - 1;
				end
			end
			awaited.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH: %s", what);
		endtask

		task check_response(logic [M_USER_W-1:0] status, logic [M_DATA_W-1:0] words);
			response_t r;
			if (awaited.size() == 0) begin
				report($sformatf("response with status %0d and no request outstanding", status));
				return;
			end
			r = awaited.pop_front();
			checked++;
			status_count[r.status]++;
			if (status !== r.status)
				report($sformatf("response %0d: status %0d, predicted %0d",
					checked, status, r.status));
			for (int k = 0; k < MSG_WORDS; k++) begin
				if (words[k*WORD_W +: WORD_W] !== r.words[k*WORD_W +: WORD_W])
					report($sformatf("response %0d: word %0d is %h, predicted %h", checked, k,
						words[k*WORD_W +: WORD_W], r.words[k*WORD_W +: WORD_W]));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [S_USER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;
	logic cfg_wr_en;
	logic [DL_W-1:0] cfg_wr_data;

	mailbox_scoreboard sb;
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;
	int cycle_count = 0;
	int requests_sent = 0;
	logic [ID_W-1:0] pool_id [POOL];
	logic [KEY_W-1:0] pool_key [POOL];

	keyed_multi_channel_mailbox_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic offer(action_t act, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
			logic [MSG_W-1:0] msg);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {msg, key, id};
		s_tuser <= act;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_request(act, id, key, msg);
		requests_sent++;
	endtask

	task automatic random_request(int send_pct);
		int idx;
		int pick;
		int roll;
		action_t act;
		logic [ID_W-1:0] id;
		logic [KEY_W-1:0] key;
		logic [MSG_W-1:0] msg;
		idx = $urandom_range(0, POOL - 1);
		id = pool_id[idx];
		key = pool_key[idx];
		pick = $urandom_range(0, 99);
		if (pick < 6)
			act = ACT_CREATE;
		else if (pick < 14)
			act = ACT_CONNECT;
		else if (pick < 14 + send_pct)
			act = ACT_SEND;
		else
			act = ACT_RECEIVE;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			id = {$urandom, $urandom};
		end else if (roll < 16) begin
			key = {$urandom, $urandom};
		end else if (roll < 20) begin
			idx = $urandom_range(0, KEY_W - 1);
			key[idx] = ~key[idx];
		end
		for (int w = 0; w < MSG_W / 32; w++)
			msg[w*32 +: 32] = $urandom;
		offer(act, id, key, msg);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_depth_limit(logic [DL_W-1:0] value);
		settle();
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		sb.limit = value;
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : receiver
		int gap;
		m_tready <= 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			if (hold_rx) begin
				gap = HOLD_CYCLES;
				hold_rx = 1'b0;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 4);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_response(m_tuser, m_tdata);
		end
	end

	initial begin : stimulus
		logic [MSG_W-1:0] ones;
		logic [MSG_W-1:0] stripes;
		logic [KEY_W-1:0] k0;
		logic [KEY_W-1:0] k1;
		int rnd_limit;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_CREATE;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		ones = '1;
		stripes = {(MSG_W / 2){2'b01}};
		pool_id[0] = '0;
		pool_key[0] = '0;
		pool_id[1] = '1;
		pool_key[1] = '1;
		for (int i = 2; i < POOL; i++) begin
			pool_id[i] = {$urandom, $urandom};
			pool_key[i] = {$urandom, $urandom};
		end
		k0 = pool_key[0];
		k1 = pool_key[1];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_CONNECT, pool_id[0], k0, '0);
		offer(ACT_SEND, pool_id[0], k0, ones);
		offer(ACT_CREATE, pool_id[0], k0, '0);
		offer(ACT_CREATE, pool_id[0], k1, '0);
		offer(ACT_SEND, pool_id[0], k0, ones);
		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_CONNECT, pool_id[0], k1, '0);
		offer(ACT_CONNECT, pool_id[0], k0, '0);
		offer(ACT_CONNECT, pool_id[0], k0, '0);
		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_SEND, pool_id[0], k1, ones);
		offer(ACT_SEND, pool_id[0], k0, ones);
		offer(ACT_SEND, pool_id[0], k0, stripes);
		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_RECEIVE, pool_id[0], k0, '0);
		offer(ACT_CREATE, pool_id[1], k1, '0);
		offer(ACT_CONNECT, pool_id[1], k1, '0);
		offer(ACT_SEND, pool_id[1], k1, '0);
		for (int i = 2; i <= 8; i++)
			offer(ACT_CREATE, pool_id[i], pool_key[i], '0);

		// Send-heavy traffic at the reset limit fills the queues before the limit drops.
		repeat (120) random_request(60);
		write_depth_limit(5'd1);
		repeat (90) random_request(30);
		write_depth_limit(5'd0);
		repeat (60) random_request(40);
		write_depth_limit(5'd31);
		quiet = 1'b1;
		hold_rx = 1'b1;
		repeat (130) random_request(43);
		quiet = 1'b0;
		rnd_limit = $urandom_range(2, 15);
		write_depth_limit(rnd_limit[DL_W-1:0]);
		repeat (100) random_request(43);
		settle();

		$display("Checked %0d responses to %0d requests: %0d ok, %0d name, %0d access, %0d level, %0d table.",
			sb.checked, requests_sent, sb.status_count[0], sb.status_count[1],
			sb.status_count[2], sb.status_count[3], sb.status_count[4]);
		$display("Depth limits 16, 1, 0, 31 and %0d were used, with one receiver stall of %0d cycles.",
			rnd_limit, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

@@ files.f @@
rtl/kmcm_pkg.sv
rtl/kmcm_ram.sv
rtl/keyed_multi_channel_mailbox_top.sv
rtl/kmcm_checker.sv
dv/tb_top.sv
